// ----- src/scpq_pkg.sv -----
// Shared types, codes and defaults for the sorted customer priority queue.
`timescale 1ns / 1ps

package scpq_pkg;

    // Default number of records the queue can hold.
    localparam int QUEUE_DEPTH_DEF = 16;

    // Operation codes carried in the func field.
    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_REMOVE = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        STAT_DONE = 2'd0,
        STAT_FULL = 2'd1,
        STAT_MISS = 2'd2
    } status_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_PLACE,
        ST_RESP
    } state_t;

    // One stored customer record, 44 bits.
    typedef struct packed {
        logic [7:0]  num;
        logic [3:0]  prio;
        logic [15:0] arrive;
        logic [15:0] service;
    } rec_t;

    // Input beat.
    typedef struct packed {
        logic        func;
        logic [7:0]  cust_num;
        logic [3:0]  cust_priority;
        logic [15:0] cust_arrive;
        logic [15:0] cust_service;
    } in_t;

    // Result beat.
    typedef struct packed {
        logic [1:0]  status;
        logic [4:0]  entry_total;
        logic        head_valid;
        logic [7:0]  head_num;
        logic [3:0]  head_priority;
        logic [15:0] head_arrive;
        logic [15:0] head_service;
    } out_t;

endpackage

// ----- src/sorted_customer_priority_queue_top.sv -----
// Top level of the sorted customer priority queue.
`timescale 1ns / 1ps

// Usage:
// A command beat on req is taken at a rising edge where start is high and
// busy is low. func selects insert (record placed by rank) or remove (first
// record whose customer number matches is deleted).
// Every command gives exactly one result beat on rsp, marked by done for a
// single cycle, carrying the status, the record count and the head record.
// The receiver cannot stall; the result must be taken in that cycle.
// Busy rises at the accepting edge and stays high through the result cycle,
// so the next command is taken in the cycle after the result at the earliest.
// One sequencer walks the record memory one slot at a time (registered
// read, then compare and move), using one shared rank comparator.
// An insert walks from the tail until the new record no longer ranks ahead
// of the one read or the head is reached, then places the new record; a
// full queue goes straight to the result, an empty one straight to placing.
// A remove reads every stored record and moves those behind the match one
// slot forward, or goes straight to the result when the queue is empty.
// Reset empties the queue at once; the memory itself is not cleared, since
// only slots below the record count are ever read.
module sorted_customer_priority_queue_top #(
    parameter int QUEUE_DEPTH = scpq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  scpq_pkg::in_t   req,
    output logic            busy,
    output logic            done,
    output scpq_pkg::out_t  rsp
);
    import scpq_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    rec_t          mem_wr_data;
    logic          mem_rd_en;
    logic [AW-1:0] mem_rd_addr;
    rec_t          mem_rd_data;

    // Sequencer and comparator.
    scpq_ctrl #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .req         (req),
        .busy        (busy),
        .done        (done),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    // Record storage.
    scpq_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule

// ----- src/scpq_store.sv -----
// Record memory: one write port and one registered read port.
`timescale 1ns / 1ps

module scpq_store #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic                clk,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  scpq_pkg::rec_t      wr_data,
    input  logic                rd_en,
    input  logic [AW-1:0]       rd_addr,
    output scpq_pkg::rec_t      rd_data
);
    import scpq_pkg::*;

    rec_t mem [DEPTH];
    rec_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- src/scpq_ctrl.sv -----
// Sequencer with the shared rank comparator that walks the record memory.
`timescale 1ns / 1ps

module scpq_ctrl #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 5
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  scpq_pkg::in_t       req,
    output logic                busy,
    output logic                done,
    output scpq_pkg::out_t      rsp,
    output logic                mem_wr_en,
    output logic [AW-1:0]       mem_wr_addr,
    output scpq_pkg::rec_t      mem_wr_data,
    output logic                mem_rd_en,
    output logic [AW-1:0]       mem_rd_addr,
    input  scpq_pkg::rec_t      mem_rd_data
);
    import scpq_pkg::*;

    // True when record a ranks strictly ahead of record b.
    function automatic logic ranks_ahead(input rec_t a, input rec_t b);
        logic res;
        if (a.prio != b.prio)
        begin
            res = (a.prio > b.prio);
        end
        else if (a.arrive != b.arrive)
        begin
            res = (a.arrive < b.arrive);
        end
        else if (a.service != b.service)
        begin
            res = (a.service < b.service);
        end
        else
        begin
            res = (a.num < b.num);
        end
        return res;
    endfunction

    state_t          state_reg, state_next;
    logic            ins_reg, ins_next;
    rec_t            rec_reg, rec_next;
    logic [AW-1:0]   idx_reg, idx_next;
    logic [AW-1:0]   pos_reg, pos_next;
    logic            found_reg, found_next;
    logic [CW-1:0]   count_reg, count_next;
    rec_t            head_reg, head_next;
    status_t         status_reg, status_next;

    logic            is_full;
    logic            none_held;
    logic [AW-1:0]   last_idx;
    logic [CW-1:0]   count_dec;
    logic            at_first;
    logic            at_last;
    logic            beats;
    logic            hit;
    logic            req_insert;

    // Shared compare results on the record just read.
    assign count_dec  = count_reg - 1'b1;
    assign last_idx   = count_dec[AW-1:0];
    assign is_full    = (count_reg == CW'(DEPTH));
    assign none_held  = (count_reg == '0);
    assign at_first   = (idx_reg == '0);
    assign at_last    = (idx_reg == last_idx);
    assign beats      = ranks_ahead(rec_reg, mem_rd_data);
    assign hit        = (mem_rd_data.num == rec_reg.num);
    assign req_insert = (req.func == FUNC_INSERT);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (req_insert)
                    begin
                        if (is_full)
                        begin
                            state_next = ST_RESP;
                        end
                        else if (none_held)
                        begin
                            state_next = ST_PLACE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                    else if (none_held)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (ins_reg)
                begin
                    state_next = (beats && !at_first) ? ST_READ : ST_PLACE;
                end
                else
                begin
                    state_next = at_last ? ST_RESP : ST_READ;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Memory control and handshake outputs.
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = pos_reg;
        mem_wr_data = rec_reg;
        done        = 1'b0;
        case (state_reg)
            ST_READ:
            begin
                mem_rd_en = 1'b1;
            end
            ST_EVAL:
            begin
                // Insert walks from the tail and moves beaten records back;
                // remove moves every record behind the match one slot forward.
                if (ins_reg && beats)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = idx_reg + 1'b1;
                    mem_wr_data = mem_rd_data;
                end
                else if (!ins_reg && found_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = idx_reg - 1'b1;
                    mem_wr_data = mem_rd_data;
                end
            end
            ST_PLACE:
            begin
                mem_wr_en = 1'b1;
            end
            ST_RESP:
            begin
                done = 1'b1;
            end
            default:
            begin
                done = 1'b0;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

    // Datapath register updates.
    always_comb
    begin
        ins_next    = ins_reg;
        rec_next    = rec_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        found_next  = found_reg;
        count_next  = count_reg;
        status_next = status_reg;
        head_next   = head_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ins_next     = req_insert;
                    rec_next     = '{num: req.cust_num, prio: req.cust_priority,
                                     arrive: req.cust_arrive, service: req.cust_service};
                    found_next   = 1'b0;
                    pos_next     = '0;
                    if (req_insert)
                    begin
                        idx_next    = last_idx;
                        status_next = is_full ? STAT_FULL : STAT_DONE;
                    end
                    else
                    begin
                        idx_next    = '0;
                        status_next = none_held ? STAT_MISS : STAT_DONE;
                    end
                end
            end
            ST_EVAL:
            begin
                if (ins_reg)
                begin
                    if (beats)
                    begin
                        if (at_first)
                        begin
                            pos_next = '0;
                        end
                        else
                        begin
                            idx_next = idx_reg - 1'b1;
                        end
                    end
                    else
                    begin
                        pos_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    if (hit)
                    begin
                        found_next = 1'b1;
                    end
                    if (at_last)
                    begin
                        if (found_reg || hit)
                        begin
                            count_next  = count_dec;
                            status_next = STAT_DONE;
                        end
                        else
                        begin
                            status_next = STAT_MISS;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_PLACE:
            begin
                count_next  = count_reg + 1'b1;
                status_next = STAT_DONE;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase

        // Keep a copy of slot zero so the head is always at hand.
        if (mem_wr_en && (mem_wr_addr == '0))
        begin
            head_next = mem_wr_data;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            found_reg <= 1'b0;
            ins_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            found_reg <= found_next;
            ins_reg   <= ins_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rec_reg    <= rec_next;
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        head_reg   <= head_next;
        status_reg <= status_next;
    end

    // Result beat, with the head fields forced to zero when the queue is empty.
    always_comb
    begin
        rsp.status        = status_reg;
        rsp.entry_total   = 5'(count_reg);
        rsp.head_valid    = !none_held;
        rsp.head_num      = none_held ? '0 : head_reg.num;
        rsp.head_priority = none_held ? '0 : head_reg.prio;
        rsp.head_arrive   = none_held ? '0 : head_reg.arrive;
        rsp.head_service  = none_held ? '0 : head_reg.service;
    end

endmodule
